FILE: rtl/core/tli_pkg.sv
// Shared constants and types for the table linear interpolator.
`timescale 1ns / 1ps
package tli_pkg;
  localparam int DEFAULT_DEPTH = 256;
  localparam logic [1:0] KIND_INTERIOR = 2'd0;
  localparam logic [1:0] KIND_FIRST    = 2'd1;
  localparam logic [1:0] KIND_LAST     = 2'd2;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load_query;   // capture query_x and point count
    logic rd_first;     // read entry 0
    logic rd_last;      // read entry n-1
    logic chk_last;     // clamp is to the last entry
    logic init_search;
    logic rd_mid;
    logic step_search;
    logic rd_lo;
    logic cap_lo;
    logic cap_hi;
    logic div_start;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic finish;
    logic emit_clamp;
  } tli_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic q_le_first;
    logic q_ge_last;
    logic search_done;
    logic div_done;
  } tli_stat_t;
endpackage

FILE: rtl/core/tli_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/tli_datapath.sv
// Datapath: table memories, search registers, serial divider and multiplier.
`timescale 1ns / 1ps
module tli_datapath import tli_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               load_we,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] entry_x,
  input  logic signed [31:0] entry_y,
  input  logic signed [31:0] query_x,
  input  logic [8:0]         points_in_use,
  input  tli_cmd_t           cmd,
  output tli_stat_t          stat,
  output logic signed [31:0] interp_value,
  output logic [1:0]         clamp_kind
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;

  logic [AW-1:0] addr, lo, hi, last;
  logic signed [31:0] xr, yr, q, xlo, ylo, yhi;
  logic [32:0] den;
  logic [32:0] rem;
  logic [15:0] t;
  logic [4:0] dcnt;
  logic signed [48:0] prod;
  logic [AW-1:0] mid;
  logic [CW-1:0] n_cl;
  logic in_range;
  logic [33:0] trial;

  assign in_range = ({{(32-AW){1'b0}}, {(AW){1'b0}}} | 32'(entry_index)) < 32'(TABLE_DEPTH);

  always_comb begin
    if (points_in_use == 9'd0) n_cl = CW'(1);
    else if (32'(points_in_use) > 32'(TABLE_DEPTH)) n_cl = CW'(TABLE_DEPTH);
    else n_cl = CW'(points_in_use);
  end

  assign mid = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_comb begin
    if (load_we) addr = AW'(entry_index);
    else if (cmd.rd_first) addr = '0;
    else if (cmd.rd_last) addr = last;
    else if (cmd.rd_mid) addr = mid;
    else if (cmd.rd_lo) addr = lo;
    else addr = hi;
  end

  tli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_xram (
    .clk(clk), .we(load_we && in_range), .addr(addr), .wdata(entry_x), .rdata(xr));
  tli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_yram (
    .clk(clk), .we(load_we && in_range), .addr(addr), .wdata(entry_y), .rdata(yr));

  assign stat.q_le_first  = q <= xr;
  assign stat.q_ge_last   = q >= xr;
  assign stat.search_done = ({1'b0, hi} - {1'b0, lo}) <= CW'(1);
  assign stat.div_done    = dcnt == 5'd0;
  assign trial = {rem, 1'b0} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q    <= query_x;
      last <= AW'(n_cl - CW'(1));
    end
    if (cmd.init_search) begin
      lo <= '0;
      hi <= last;
    end
    if (cmd.step_search) begin
      if (xr <= q) lo <= mid;
      else hi <= mid;
    end
    if (cmd.cap_lo) begin
      xlo <= xr;
      ylo <= yr;
    end
    if (cmd.cap_hi) begin
      den <= 33'(signed'({xr[31], xr}) - signed'({xlo[31], xlo}));
      yhi <= yr;
    end
    if (cmd.div_start) begin
      rem  <= 33'(signed'({q[31], q}) - signed'({xlo[31], xlo}));
      dcnt <= 5'd16;
      t    <= '0;
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        t   <= {t[14:0], 1'b1};
      end else begin
        rem <= {rem[31:0], 1'b0};
        t   <= {t[14:0], 1'b0};
      end
      dcnt <= dcnt - 5'd1;
    end
    // y difference into den, then one 33x17 signed product
    if (cmd.mul_lo) begin
      den  <= 33'(signed'({yhi[31], yhi}) - signed'({ylo[31], ylo}));
    end
    if (cmd.mul_hi) begin
      prod <= 49'(signed'(den) * signed'({1'b0, t}));
    end
    if (cmd.finish) begin
      interp_value <= ylo + 32'(prod >>> 16);
      clamp_kind   <= KIND_INTERIOR;
    end
    if (cmd.emit_clamp) begin
      interp_value <= yr;
      clamp_kind   <= cmd.chk_last ? KIND_LAST : KIND_FIRST;
    end
  end
endmodule

FILE: rtl/core/tli_ctrl.sv
// Controller state machine for queries.
`timescale 1ns / 1ps
module tli_ctrl import tli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      go,
  input  tli_stat_t stat,
  output tli_cmd_t  cmd,
  output logic      busy,
  output logic      done
);
  localparam logic [3:0] S_IDLE = 4'd0, S_F = 4'd1, S_L = 4'd2, S_CL = 4'd3,
    S_SR = 4'd4, S_SC = 4'd5, S_LO = 4'd6, S_HI = 4'd7, S_HC = 4'd8,
    S_DIV = 4'd9, S_M1 = 4'd10, S_M2 = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13;
  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = state != S_IDLE;
  assign done = state == S_OUT;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (go) begin
        cmd.load_query = 1'b1;
        cmd.rd_first = 1'b1;
        state_next = S_F;
      end
      S_F: begin
        if (stat.q_le_first) begin
          cmd.emit_clamp = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.rd_last = 1'b1;
          state_next = S_L;
        end
      end
      S_L: begin
        if (stat.q_ge_last) begin
          cmd.chk_last = 1'b1;
          cmd.emit_clamp = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.init_search = 1'b1;
          state_next = S_CL;
        end
      end
      S_CL: begin
        if (stat.search_done) begin
          cmd.rd_lo = 1'b1;
          state_next = S_LO;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_SR;
        end
      end
      S_SR: begin
        cmd.step_search = 1'b1;
        state_next = S_CL;
      end
      S_LO: begin
        cmd.cap_lo = 1'b1;
        state_next = S_HI;
      end
      S_HI: state_next = S_HC;
      S_HC: begin
        cmd.cap_hi = 1'b1;
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_M1;
        else cmd.div_step = 1'b1;
      end
      S_M1: begin
        cmd.mul_lo = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_hi = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/table_linear_interpolator.sv
// Top level of the piecewise linear interpolation table.
`timescale 1ns / 1ps
//  channel   signals                               handshake
//  input     action entry_index entry_x entry_y    start & !busy
//            query_x
//  result    interp_value clamp_kind               strobe, one cycle
//  config    cfg_we cfg_data (points_in_use)       cfg_we
// A load beat gives no result and leaves busy low.
// A query beat holds busy until its result: it reads the first entry and,
// unless clamped there, the last entry; if not clamped to either, it
// runs at most ceil(log2(n-1)) search steps, each a read and a compare on
// the single-port tables, then a 16-step restoring divider and a multiply.
// The strobe sits in the last busy cycle; the next beat can be taken in the cycle after.
// Reset clears the controller and sets points_in_use to 1; the tables
// are not cleared. The receiver cannot stall the strobe.
module table_linear_interpolator import tli_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] entry_x,
  input  logic signed [31:0] entry_y,
  input  logic signed [31:0] query_x,
  output logic               strobe,
  output logic signed [31:0] interp_value,
  output logic [1:0]         clamp_kind,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data
);
  logic [8:0] points_in_use;
  tli_cmd_t  cmd;
  tli_stat_t stat;
  logic ctrl_busy;

  always_ff @(posedge clk) begin
    if (rst) points_in_use <= 9'd1;
    else if (cfg_we) points_in_use <= cfg_data;
  end

  assign busy = ctrl_busy;

  tli_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(start && !ctrl_busy && action), .stat(stat),
    .cmd(cmd), .busy(ctrl_busy), .done(strobe));

  tli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .load_we(start && !ctrl_busy && !action), .entry_index(entry_index),
    .entry_x(entry_x), .entry_y(entry_y), .query_x(query_x),
    .points_in_use(points_in_use), .cmd(cmd), .stat(stat),
    .interp_value(interp_value), .clamp_kind(clamp_kind));

  // Strobe only comes in a busy cycle.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe outside query");
  // A result never follows directly from an idle cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !strobe) else $error("strobe without work");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    strobe |-> clamp_kind != 2'd3) else $error("bad kind");
endmodule

FILE: bench/testbench.sv
// Self-checking bench for the table linear interpolator: table loads, queries, point-count sweeps.
`timescale 1ns / 1ps
module testbench;
  import tli_pkg::*;

  localparam int DEPTH       = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam bit ACT_LOAD    = 1'b0;
  localparam bit ACT_QUERY   = 1'b1;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               action;
  logic [7:0]         entry_index;
  logic signed [31:0] entry_x;
  logic signed [31:0] entry_y;
  logic signed [31:0] query_x;
  logic               strobe;
  logic signed [31:0] interp_value;
  logic [1:0]         clamp_kind;
  logic               cfg_we;
  logic [8:0]         cfg_data;

  table_linear_interpolator #(.TABLE_DEPTH(DEPTH)) dut (
    .clk, .rst, .start, .busy, .action, .entry_index, .entry_x, .entry_y,
    .query_x, .strobe, .interp_value, .clamp_kind, .cfg_we, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result as the bench expects it.
  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         kind;
  } interp_t;

  // Shadow of the block's state.
  logic signed [31:0] shadow_x [DEPTH];
  logic signed [31:0] shadow_y [DEPTH];
  logic [8:0]         shadow_points;
  interp_t            pending_results [$];

  int  mismatches;
  int  cycles;
  bit  idle_free;   // long stretch with no gaps on the sender side

  // Interpolation as the block should compute it.
  function automatic interp_t interpolate(logic signed [31:0] q);
    interp_t            r;
    int                 n, lo, hi, mid;
    logic signed [32:0] dx, dq;
    logic signed [33:0] dy;
    logic [48:0]        num;
    logic [32:0]        den;
    logic [48:0]        frac;
    logic signed [63:0] prod;
    n = shadow_points;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    if (q <= shadow_x[0]) begin
      r.value = shadow_y[0];
      r.kind  = KIND_FIRST;
    end else if (q >= shadow_x[n-1]) begin
      r.value = shadow_y[n-1];
      r.kind  = KIND_LAST;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (shadow_x[mid] <= q) lo = mid;
        else hi = mid;
      end
      dx   = 33'(shadow_x[hi]) - 33'(shadow_x[lo]);
      dq   = 33'(q) - 33'(shadow_x[lo]);
      num  = {16'(0), dq[32:0]} << 16;
      den  = dx;
      frac = num / {16'(0), den};
      if (frac > 49'd65535) frac = 49'd65535;
      dy   = 34'(shadow_y[hi]) - 34'(shadow_y[lo]);
      prod = 64'(dy) * $signed({1'b0, frac[15:0]});
      // arithmetic shift floors toward minus infinity
      r.value = 32'(64'(shadow_y[lo]) + (prod >>> 16));
      r.kind  = KIND_INTERIOR;
    end
    return r;
  endfunction

  // One beat on the command port; waits for acceptance.
  task automatic send_beat(bit act, logic [7:0] idx, logic signed [31:0] ex,
                           logic signed [31:0] ey, logic signed [31:0] qx);
    while (!idle_free && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    entry_index <= idx;
    entry_x     <= ex;
    entry_y     <= ey;
    query_x     <= qx;
    // busy only moves at the rising edge, so mid-cycle tells the next edge
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    // beat taken at this edge
    if (act == ACT_LOAD) begin
      shadow_x[idx] = ex;
      shadow_y[idx] = ey;
    end else begin
      pending_results = {pending_results, interpolate(qx)};
    end
  endtask

  // Lower start and let the block drain before touching the register.
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_points(logic [8:0] v);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow_points = v;
    @(posedge clk);
  endtask

  // Sorted table of n entries over a random span; x strictly increasing.
  task automatic load_sorted(int n, bit wide);
    logic signed [31:0] x, y;
    int unsigned        stepmax;
    stepmax = wide ? (32'hFFFF_FFF0 / n) : 32'h0003_0000;
    x = wide ? 32'sh8000_0000 + $urandom_range(3) :
               $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: y = $urandom;
        1: y = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        default: y = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      endcase
      send_beat(ACT_LOAD, 8'(i), x, y, $urandom);
      x = x + 32'($urandom_range(stepmax, 1));
    end
  endtask

  // Query point: mostly inside the loaded span, sometimes anywhere.
  function automatic logic signed [31:0] pick_query(int n);
    int k;
    k = (n < 1) ? 0 : ((n > DEPTH) ? DEPTH - 1 : n - 1);
    case ($urandom_range(9))
      0: return $urandom;
      1: return shadow_x[$urandom_range(k)];
      2: return shadow_x[0] - 1;
      3: return shadow_x[k];
      default: begin
        logic signed [63:0] span;
        span = 64'(shadow_x[k]) - 64'(shadow_x[0]);
        return 32'(64'(shadow_x[0]) +
                   (span * $urandom_range(1000)) / 1000);
      end
    endcase
  endfunction

  // Result checker: the receiver cannot stall, so sample every strobe.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %h kind %0d", interp_value, clamp_kind);
      end else begin
        interp_t want;
        want = pending_results.pop_front();
        if (want.value !== interp_value || want.kind !== clamp_kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want value %h kind %0d, got value %h kind %0d",
                     want.value, want.kind, interp_value, clamp_kind);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Directed rows. Expected value typed in where obvious, else predictor.
  typedef struct {
    bit                 act;
    logic [7:0]         idx;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] qx;
    bit                 typed;
    logic signed [31:0] want_value;
    logic [1:0]         want_kind;
  } row_t;

  row_t directed [] = '{
    // single point in use: clamp both ways
    '{ACT_LOAD,  8'd0,   32'sh0000_0000, 32'sh1234_5678, 0, 0, 0, 0},
    '{ACT_QUERY, 8'd0,   0, 0, 32'sh8000_0000, 1, 32'sh1234_5678, KIND_FIRST},
    '{ACT_QUERY, 8'd0,   0, 0, 32'sh0000_0000, 1, 32'sh1234_5678, KIND_FIRST},
    '{ACT_QUERY, 8'd0,   0, 0, 32'sh0000_0001, 1, 32'sh1234_5678, KIND_LAST},
    '{ACT_QUERY, 8'd0,   0, 0, 32'sh7FFF_FFFF, 1, 32'sh1234_5678, KIND_LAST},
    // extremes of the fields
    '{ACT_LOAD,  8'd0,   32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0},
    '{ACT_LOAD,  8'd1,   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0},
    '{ACT_LOAD,  8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0}
  };
  // queries over the full-span two-point table (points_in_use = 2)
  row_t directed2 [] = '{
    '{ACT_QUERY, 8'd0, 0, 0, 32'sh8000_0000, 1, 32'sh8000_0000, KIND_FIRST},
    '{ACT_QUERY, 8'd0, 0, 0, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, KIND_LAST},
    '{ACT_QUERY, 8'd0, 0, 0, 32'sh8000_0001, 0, 0, 0},
    '{ACT_QUERY, 8'd0, 0, 0, 32'sh0000_0000, 0, 0, 0},
    '{ACT_QUERY, 8'd0, 0, 0, 32'sh7FFF_FFFE, 0, 0, 0},
    '{ACT_QUERY, 8'd0, 0, 0, 32'shFFFF_FFFF, 0, 0, 0}
  };

  task automatic run_rows(row_t rows []);
    foreach (rows[i]) begin
      send_beat(rows[i].act, rows[i].idx, rows[i].ex, rows[i].ey, rows[i].qx);
      if (rows[i].act == ACT_QUERY && rows[i].typed) begin
        // swap the predicted entry for the typed-in one
        pending_results[$].value = rows[i].want_value;
        pending_results[$].kind  = rows[i].want_kind;
      end
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0; action = ACT_LOAD; entry_index = '0;
    entry_x = '0; entry_y = '0; query_x = '0;
    cfg_we = 1'b0; cfg_data = 9'd1;
    mismatches = 0; cycles = 0; idle_free = 1'b0;
    shadow_points = 9'd1;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_rows(directed);
    write_points(9'd2);
    run_rows(directed2);
    // zero counts as one point, oversize as full depth
    write_points(9'd0);
    send_beat(ACT_QUERY, 0, 0, 0, 32'sh8000_0000);
    send_beat(ACT_QUERY, 0, 0, 0, 32'sh0000_0000);
    load_sorted(DEPTH, 1'b1);
    write_points(9'd511);
    for (int i = 0; i < 6; i++) send_beat(ACT_QUERY, 0, 0, 0, pick_query(DEPTH));
    write_points(9'd256);
    for (int i = 0; i < 30; i++) send_beat(ACT_QUERY, 0, 0, 0, pick_query(DEPTH));

    // random phases: reload a small sorted table, then query it
    for (int phase = 0; phase < 8; phase++) begin
      n = (phase == 0) ? $urandom_range(40, 16) : $urandom_range(12, 2);
      idle_free = (phase == 7);
      write_points(9'(n));
      load_sorted(n, $urandom_range(1));
      for (int i = 0; i < 22; i++) begin
        // stray loads above the span in use leave queries untouched
        if ($urandom_range(9) == 0 && n < DEPTH)
          send_beat(ACT_LOAD, 8'($urandom_range(DEPTH - 1, n)), $urandom, $urandom, 0);
        else
          send_beat(ACT_QUERY, 0, 0, 0, pick_query(n));
      end
    end
    idle_free = 1'b0;

    quiesce();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/tli_pkg.sv
rtl/core/tli_ram.sv
rtl/core/tli_datapath.sv
rtl/core/tli_ctrl.sv
rtl/core/table_linear_interpolator.sv
bench/testbench.sv
